>>> sv/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg: shared types, constants and helper functions
// Row width limits, filter codes, the front-to-back command word, the
// register clamps and the Paeth predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

  localparam int MAX_ROW_BYTES = 16384;
  localparam int IDX_W         = $clog2(MAX_ROW_BYTES);
  localparam int COL_W         = $clog2(MAX_ROW_BYTES + 1);
  localparam int BPP_W         = 3;
  localparam int RB_W          = 15;
  localparam int MAX_BPP       = 4;
  localparam int SEL_W         = $clog2(MAX_BPP);
  localparam int LEFT_W        = 8 * MAX_BPP;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  localparam logic [7:0] FILT_MAX_CODE = 8'd4;

  typedef enum logic {
    CFG_BPP       = 1'b0,
    CFG_ROW_BYTES = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic             bad;
    logic             last;
    logic             row_start;
    logic             first_row;
    filt_t            filt;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic [7:0]       up;
  } cmd_t;

  // bytes_per_pixel -> left tap select (bpp - 1), clamped to 1..MAX_BPP
  function automatic logic [SEL_W-1:0] bpp_sel(input logic [BPP_W-1:0] bpp);
    logic [SEL_W-1:0] sel;
    if (bpp == '0) begin
      sel = '0;
    end else if (bpp > BPP_W'(MAX_BPP)) begin
      sel = SEL_W'(MAX_BPP - 1);
    end else begin
      sel = SEL_W'(bpp - BPP_W'(1));
    end
    return sel;
  endfunction

  function automatic logic [COL_W-1:0] rb_clamp(input logic [RB_W-1:0] rb);
    logic [COL_W-1:0] v;
    if (rb == '0) begin
      v = COL_W'(1);
    end else if (COL_W'(rb) > COL_W'(MAX_ROW_BYTES)) begin
      v = COL_W'(MAX_ROW_BYTES);
    end else begin
      v = COL_W'(rb);
    end
    return v;
  endfunction

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] sa, sb, sc, da, db, dc;
    logic [7:0] pick;
    sa = $signed({3'b000, a});
    sb = $signed({3'b000, b});
    sc = $signed({3'b000, c});
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - sc - sc;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) begin
      pick = a;
    end else if (db <= dc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

endpackage

`default_nettype wire

>>> sv/psu_if.sv
// ----------------------------------------------------------------------------
// psu_if: valid/ready channels of the unfilter
// Stream input channel and reconstructed byte output channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface psu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       start_of_image;

  modport source(output valid, output byte_value, output start_of_image, input ready);
  modport sink(input valid, input byte_value, input start_of_image, output ready);
endinterface

interface psu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_row;
  logic       bad_filter;

  modport source(output valid, output out_byte, output end_of_row, output bad_filter,
                 input ready);
  modport sink(input valid, input out_byte, input end_of_row, input bad_filter,
               output ready);
endinterface

`default_nettype wire

>>> sv/psu_line_buf.sv
// ----------------------------------------------------------------------------
// psu_line_buf: previous-row byte store
// One write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_line_buf import psu_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem_r [MAX_ROW_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> sv/psu_front.sv
// ----------------------------------------------------------------------------
// psu_front: stream parser
// Tracks row position, filter code, first row and error; issues the up-byte
// read and hands one command per result to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_front import psu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  psu_in_if.sink           in_ch,
  input  logic [RB_W-1:0]  row_bytes,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  logic [7:0]       rd_data,
  output logic [IDX_W-1:0] probe_idx,
  input  logic             probe_hit,
  input  logic             q_full,
  output logic             push,
  output cmd_t             push_cmd
);

  logic [COL_W-1:0] col_r, col_nxt;
  filt_t            filt_r, filt_nxt;
  logic             first_r, first_nxt;
  logic             err_r, err_nxt;
  logic             f1_v_r, f1_v_nxt;
  cmd_t             f1_cmd_r, f1_cmd_nxt;

  logic [COL_W-1:0] col_dec;
  logic [COL_W-1:0] rb_c;
  logic             f1_hit;
  logic             hazard;
  logic             acc;
  logic             load;
  logic             last;

  assign col_dec   = col_r - COL_W'(1);
  assign rd_addr   = col_dec[IDX_W-1:0];
  assign probe_idx = rd_addr;
  assign rb_c      = rb_clamp(row_bytes);

  // hold a data byte whose up byte is still being rebuilt downstream
  assign f1_hit = f1_v_r && !f1_cmd_r.bad && (f1_cmd_r.idx == rd_addr);
  assign hazard = (col_r != '0) && !err_r && !first_r && (f1_hit || probe_hit);

  assign push        = f1_v_r && !q_full;
  assign in_ch.ready = (!f1_v_r || !q_full) && !hazard;
  assign acc         = in_ch.valid && in_ch.ready;
  assign rd_en       = acc;

  always_comb begin
    push_cmd    = f1_cmd_r;
    push_cmd.up = f1_cmd_r.first_row ? 8'd0 : rd_data;
  end

  always_comb begin
    col_nxt   = col_r;
    filt_nxt  = filt_r;
    first_nxt = first_r;
    err_nxt   = err_r;
    load      = 1'b0;
    last      = 1'b0;

    f1_cmd_nxt           = f1_cmd_r;
    f1_cmd_nxt.bad       = 1'b0;
    f1_cmd_nxt.last      = 1'b0;
    f1_cmd_nxt.row_start = 1'b0;
    f1_cmd_nxt.first_row = first_r;
    f1_cmd_nxt.filt      = filt_r;
    f1_cmd_nxt.idx       = rd_addr;
    f1_cmd_nxt.data      = in_ch.byte_value;
    f1_cmd_nxt.up        = 8'd0;

    if (acc) begin
      if (in_ch.start_of_image) begin
        col_nxt   = '0;
        first_nxt = 1'b1;
        err_nxt   = 1'b0;
      end
      if (!err_nxt) begin
        if (col_nxt == '0) begin
          if (in_ch.byte_value > FILT_MAX_CODE) begin
            f1_cmd_nxt.bad  = 1'b1;
            f1_cmd_nxt.data = 8'd0;
            load            = 1'b1;
            err_nxt         = 1'b1;
          end else begin
            filt_nxt = filt_t'(in_ch.byte_value[2:0]);
            col_nxt  = COL_W'(1);
          end
        end else begin
          last                 = (col_r >= rb_c);
          load                 = 1'b1;
          f1_cmd_nxt.last      = last;
          f1_cmd_nxt.row_start = (col_r == COL_W'(1));
          if (last) begin
            col_nxt   = '0;
            first_nxt = 1'b0;
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
      end
    end

    if (load) begin
      f1_v_nxt = 1'b1;
    end else if (push) begin
      f1_v_nxt = 1'b0;
    end else begin
      f1_v_nxt = f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      filt_r  <= FILT_NONE;
      first_r <= 1'b1;
      err_r   <= 1'b0;
      f1_v_r  <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      filt_r  <= filt_nxt;
      first_r <= first_nxt;
      err_r   <= err_nxt;
      f1_v_r  <= f1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      f1_cmd_r <= f1_cmd_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/psu_queue.sv
// ----------------------------------------------------------------------------
// psu_queue: command queue between front and back
// Short FIFO; also reports whether any queued data command targets a given
// line buffer address.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_queue import psu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cmd_t             push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_v,
  output cmd_t             head,
  input  logic [IDX_W-1:0] probe_idx,
  output logic             probe_hit
);

  cmd_t              ent_r [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vld_r, vld_nxt;
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full   = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_v = (cnt_r != '0);
  assign head   = ent_r[rd_ptr_r];

  always_comb begin
    probe_hit = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (vld_r[i] && !ent_r[i].bad && (ent_r[i].idx == probe_idx)) begin
        probe_hit = 1'b1;
      end
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (pop) begin
      vld_nxt[rd_ptr_r] = 1'b0;
    end
    if (push) begin
      vld_nxt[wr_ptr_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      vld_r    <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (push) begin
        wr_ptr_r <= QPTR_W'((32'(wr_ptr_r) + 1) % QUEUE_DEPTH);
      end
      if (pop) begin
        rd_ptr_r <= QPTR_W'((32'(rd_ptr_r) + 1) % QUEUE_DEPTH);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_v)
    else $error("queue pop while empty");
  a_cnt_vld: assert property (@(posedge clk) disable iff (!rst_n)
      $countones(vld_r) == 32'(cnt_r))
    else $error("queue count and valid bits disagree");

endmodule

`default_nettype wire

>>> sv/psu_back.sv
// ----------------------------------------------------------------------------
// psu_back: byte reconstruction
// Applies the row filter with the left and up-left history, writes the
// result to the line buffer and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_back import psu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [BPP_W-1:0] bytes_per_pixel,
  input  logic             head_v,
  input  cmd_t             head,
  output logic             pop,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output logic [7:0]       wr_data,
  psu_out_if.source        out_ch
);

  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [LEFT_W-1:0] upl_r, upl_nxt;
  logic              out_v_r;
  logic [7:0]        out_byte_r;
  logic              out_eor_r;
  logic              out_bad_r;

  logic [SEL_W-1:0]  sel;
  logic [7:0]        a, b, c, pred, val;
  logic [8:0]        ab_sum;

  assign pop = head_v && (!out_v_r || out_ch.ready);
  assign sel = bpp_sel(bytes_per_pixel);

  always_comb begin
    a      = head.row_start ? 8'd0 : left_r[8*sel +: 8];
    c      = head.row_start ? 8'd0 : upl_r[8*sel +: 8];
    b      = head.up;
    ab_sum = {1'b0, a} + {1'b0, b};
    case (head.filt)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    val = head.data + pred;

    if (head.row_start) begin
      left_nxt = {{(LEFT_W-8){1'b0}}, val};
      upl_nxt  = {{(LEFT_W-8){1'b0}}, b};
    end else begin
      left_nxt = {left_r[LEFT_W-9:0], val};
      upl_nxt  = {upl_r[LEFT_W-9:0], b};
    end
  end

  assign wr_en   = pop && !head.bad;
  assign wr_addr = head.idx;
  assign wr_data = val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      left_r  <= '0;
      upl_r   <= '0;
    end else begin
      if (pop) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (wr_en) begin
        left_r <= left_nxt;
        upl_r  <= upl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r <= head.bad ? 8'd0 : val;
      out_eor_r  <= head.bad ? 1'b0 : head.last;
      out_bad_r  <= head.bad;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.end_of_row = out_eor_r;
  assign out_ch.bad_filter = out_bad_r;

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
      (out_v_r && out_bad_r) |-> (!out_eor_r && out_byte_r == 8'd0))
    else $error("error result carries data");
  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n) pop |=> out_v_r)
    else $error("popped command not registered");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (out_v_r && !out_ch.ready) |=> (out_v_r && $stable(out_byte_r)))
    else $error("stalled result lost");

endmodule

`default_nettype wire

>>> sv/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter: PNG filter reconstruction
// Rebuilds raw bytes from the inflated stream under None, Sub, Up, Average
// and Paeth, with the previous row held in a line buffer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        byte_value[7:0], start_of_image
//  out_ch   out  valid/ready        out_byte[7:0], end_of_row, bad_filter
//  cfg      in   cfg_we             cfg_idx (0 bpp, 1 row_bytes), cfg_data[14:0]
//
//  One stream byte per cycle unless the front stalls; a result goes through
//  the front command register and a queue entry into the output register.
//  The front stalls while the up byte it needs is still queued for the line
//  buffer write, which happens on rows of a few bytes, and when the queue is
//  full behind a held output. Synchronous active-low reset; the line buffer
//  is not cleared, the first row of each image reads up bytes as zero. A
//  stalled output holds its result while the queue keeps taking bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter import psu_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  psu_in_if.sink          in_ch,
  psu_out_if.source       out_ch,
  input  logic            cfg_we,
  input  cfg_idx_t        cfg_idx,
  input  logic [RB_W-1:0] cfg_data
);

  logic [BPP_W-1:0] bpp_r;
  logic [RB_W-1:0]  rb_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [IDX_W-1:0] probe_idx;
  logic             probe_hit;
  logic             q_full;
  logic             push;
  cmd_t             push_cmd;
  logic             pop;
  logic             head_v;
  cmd_t             head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= BPP_W'(1);
      rb_r  <= RB_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BPP:       bpp_r <= cfg_data[BPP_W-1:0];
        CFG_ROW_BYTES: rb_r  <= cfg_data;
        default:       ;
      endcase
    end
  end

  psu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .row_bytes (rb_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .probe_idx (probe_idx),
    .probe_hit (probe_hit),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  psu_line_buf u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  psu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_v    (head_v),
    .head      (head),
    .probe_idx (probe_idx),
    .probe_hit (probe_hit)
  );

  psu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .bytes_per_pixel (bpp_r),
    .head_v          (head_v),
    .head            (head),
    .pop             (pop),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .out_ch          (out_ch)
  );

endmodule

`default_nettype wire

>>> tb/png_scanline_unfilter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter_tb: self-checking bench for the PNG row unfilter
// Streams images of filter and data bytes through the valid/ready input,
// rebuilds every byte in a local line-buffer copy and compares each output
// transfer in order. Random gaps on both sides, long output holds, bad
// filter codes, start marks mid row and register changes between phases.
// ----------------------------------------------------------------------------

import psu_pkg::*;

typedef struct packed {
  logic [7:0] value;
  logic       eor;
  logic       bad;
} raw_byte_t;

class unfilter_board;
  logic [7:0]        line_buf [MAX_ROW_BYTES];
  int unsigned       fill;
  logic [LEFT_W-1:0] left_hist;
  logic [LEFT_W-1:0] upleft_hist;
  int unsigned       col;
  filt_t             filt;
  bit                first_row;
  bit                err;
  logic [BPP_W-1:0]  bpp_reg;
  logic [RB_W-1:0]   rb_reg;
  raw_byte_t         owed_bytes [$];
  int unsigned       faults;
  int unsigned       results;
  int unsigned       bad_seen;

  function new();
    fill        = 0;
    left_hist   = '0;
    upleft_hist = '0;
    col         = 0;
    filt        = FILT_NONE;
    first_row   = 1'b1;
    err         = 1'b0;
    bpp_reg     = BPP_W'(1);
    rb_reg      = RB_W'(1);
    faults      = 0;
    results     = 0;
    bad_seen    = 0;
  endfunction

  function void set_reg(cfg_idx_t idx, logic [RB_W-1:0] v);
    if (idx == CFG_BPP) begin
      bpp_reg = v[BPP_W-1:0];
    end else begin
      rb_reg = v;
    end
  endfunction

  function int unsigned bpp_eff();
    int unsigned n;
    n = bpp_reg;
    if (n == 0) n = 1;
    if (n > MAX_BPP) n = MAX_BPP;
    return n;
  endfunction

  function int unsigned rb_eff();
    int unsigned n;
    n = rb_reg;
    if (n == 0) n = 1;
    if (n > MAX_ROW_BYTES) n = MAX_ROW_BYTES;
    return n;
  endfunction

  function logic [7:0] paeth_guess(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int est, da, db, dc;
    est = int'(a) + int'(b) - int'(c);
    da  = est - int'(a);
    db  = est - int'(b);
    dc  = est - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // returns 1 when the byte is discarded by a latched error
  function bit take_stream_byte(logic [7:0] b, logic s);
    int unsigned k, shift;
    logic [7:0]  a, up, c, pred, val;
    raw_byte_t   r;
    if (s) begin
      err       = 1'b0;
      first_row = 1'b1;
      col       = 0;
    end
    if (err) return 1'b1;
    if (col == 0) begin
      left_hist   = '0;
      upleft_hist = '0;
      if (b > 8'd4) begin
        err     = 1'b1;
        r.value = 8'h00;
        r.eor   = 1'b0;
        r.bad   = 1'b1;
        owed_bytes.push_back(r);
        return 1'b0;
      end
      filt = filt_t'(b[2:0]);
      col  = 1;
      return 1'b0;
    end
    k = col - 1;
    if (k >= MAX_ROW_BYTES) k = MAX_ROW_BYTES - 1;
    shift = 8 * (bpp_eff() - 1);
    a  = left_hist[shift +: 8];
    c  = upleft_hist[shift +: 8];
    up = first_row ? 8'h00 : line_buf[k];
    case (filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = 8'((9'(a) + 9'(up)) >> 1);
      FILT_PAETH: pred = paeth_guess(a, up, c);
      default:    pred = 8'h00;
    endcase
    val = b + pred;
    line_buf[k] = val;
    if (k == fill) fill++;
    left_hist   = {left_hist[LEFT_W-9:0], val};
    upleft_hist = {upleft_hist[LEFT_W-9:0], up};
    r.value = val;
    r.eor   = (k + 1 >= rb_eff());
    r.bad   = 1'b0;
    if (r.eor) begin
      col       = 0;
      first_row = 1'b0;
    end else begin
      col = k + 2;
    end
    owed_bytes.push_back(r);
    return 1'b0;
  endfunction

  function void check_output(raw_byte_t got);
    raw_byte_t want;
    if (owed_bytes.size() == 0) begin
      $display("%0t: unexpected output byte %0h eor %0b bad %0b", $time,
               got.value, got.eor, got.bad);
      faults++;
      return;
    end
    want = owed_bytes.pop_front();
    results++;
    if (want.bad) bad_seen++;
    if (got.value !== want.value) begin
      $display("%0t: out_byte expected %0h actual %0h", $time, want.value, got.value);
      faults++;
    end
    if (got.eor !== want.eor) begin
      $display("%0t: end_of_row expected %0b actual %0b", $time, want.eor, got.eor);
      faults++;
    end
    if (got.bad !== want.bad) begin
      $display("%0t: bad_filter expected %0b actual %0b", $time, want.bad, got.bad);
      faults++;
    end
  endfunction
endclass

module png_scanline_unfilter_tb;

  localparam int  RAND_ITEMS = 1500;
  localparam int  LONG_ROW   = 200;
  localparam int  SETTLE     = 10;
  localparam int  HOLD_LEN   = 300;
  localparam real LIMIT_NS   = 6000000.0;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  cfg_idx_t        cfg_idx;
  logic [RB_W-1:0] cfg_data;

  psu_in_if  in_ch ();
  psu_out_if out_ch ();

  png_scanline_unfilter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  unfilter_board sb = new();

  bit          calm;
  int          hold_cycles;
  int unsigned live_bytes;
  int unsigned settings;
  int unsigned holds_done;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t: timeout, %0d results outstanding", $time, sb.owed_bytes.size());
    $display("status: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.byte_value     <= b;
    in_ch.start_of_image <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!sb.take_stream_byte(b, s)) live_bytes++;
  endtask

  task automatic send_row(input logic s, input logic [7:0] code, input int n_data);
    send_byte(code, s);
    for (int i = 0; i < n_data; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [BPP_W-1:0] bpp, input logic [RB_W-1:0] rb);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_BPP;
    cfg_data <= RB_W'(bpp);
    @(posedge clk);
    sb.set_reg(CFG_BPP, RB_W'(bpp));
    cfg_idx  <= CFG_ROW_BYTES;
    cfg_data <= rb;
    @(posedge clk);
    sb.set_reg(CFG_ROW_BYTES, rb);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // output side: random stall per result, long hold on request
  initial begin
    int        gap;
    raw_byte_t got;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
        holds_done++;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 7);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.value = out_ch.out_byte;
      got.eor   = out_ch.end_of_row;
      got.bad   = out_ch.bad_filter;
      sb.check_output(got);
    end
  end

  initial begin
    int unsigned base, rbe, phase_no, rows, sel, n;
    logic [BPP_W-1:0] bpp_raw;
    logic [RB_W-1:0]  rb_raw;
    logic             s;

    calm        = 1'b0;
    hold_cycles = 0;
    live_bytes  = 0;
    settings    = 0;
    holds_done  = 0;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= CFG_BPP;
    cfg_data             <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.byte_value     <= 8'h00;
    in_ch.start_of_image <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one row per filter, then error handling and start marks
    cfg_write(3'd2, RB_W'(4));
    send_byte(8'(FILT_NONE), 1'b1);
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'(FILT_SUB), 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(8'(FILT_UP), 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'(FILT_AVG), 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'hFE, 1'b0);
    send_byte(8'(FILT_PAETH), 1'b0);
    send_byte(8'h7F, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'(FILT_SUB), 1'b1);
    send_byte(8'h10, 1'b0); send_byte(8'h20, 1'b0);
    send_byte(8'(FILT_PAETH), 1'b1);
    send_byte(8'h33, 1'b0);
    wait_idle();
    // shrink the row under an open row: next data byte closes it
    cfg_write(3'd0, RB_W'(1));
    send_byte(8'h44, 1'b0);
    wait_idle();

    // long row under the largest row setting, closed by shrinking the row
    calm = 1'b1;
    cfg_write(3'd4, RB_W'(32767));
    send_row(1'b1, 8'($urandom_range(0, 4)), LONG_ROW);
    wait_idle();
    cfg_write(3'd4, RB_W'(1));
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_idle();
    calm = 1'b0;

    base     = live_bytes;
    phase_no = 0;
    while (live_bytes - base < RAND_ITEMS) begin
      phase_no++;
      bpp_raw = 3'($urandom_range(0, 7));
      sel     = $urandom_range(0, 19);
      if (sel == 0) rb_raw = '0;
      else if (sel < 15) rb_raw = RB_W'($urandom_range(1, 8));
      else if (sel < 19) rb_raw = RB_W'($urandom_range(9, 40));
      else rb_raw = RB_W'($urandom_range(41, 200));
      cfg_write(bpp_raw, rb_raw);
      calm = ($urandom_range(0, 3) == 0);
      rbe  = sb.rb_eff();
      rows = $urandom_range(2, 6);
      for (int r = 0; r < rows; r++) begin
        if (r == 1 && (phase_no == 2 || phase_no == 9)) hold_cycles = HOLD_LEN;
        s = sb.err || sb.col != 0 || (!sb.first_row && rbe > sb.fill) ||
            ($urandom_range(0, 9) == 0);
        sel = $urandom_range(0, 39);
        if (sel == 0) begin
          send_byte(8'($urandom_range(5, 255)), s);
          n = $urandom_range(0, 4);
          for (int j = 0; j < n; j++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (sel == 1) begin
          send_row(s, 8'($urandom_range(0, 4)), $urandom_range(0, rbe - 1));
        end else begin
          send_row(s, 8'($urandom_range(0, 4)), rbe);
        end
      end
      wait_idle();
    end

    $display("ran %0d stream bytes (%0d random) under %0d register settings",
             live_bytes, live_bytes - base, settings);
    $display("checked %0d output bytes, %0d bad-filter results, %0d long holds",
             sb.results, sb.bad_seen, holds_done);
    if (sb.faults == 0 && sb.owed_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/psu_pkg.sv
sv/psu_if.sv
sv/psu_line_buf.sv
sv/psu_front.sv
sv/psu_queue.sv
sv/psu_back.sv
sv/png_scanline_unfilter.sv
tb/png_scanline_unfilter_tb.sv
